FILE: hdl/pwsc_pkg.sv
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared types, constants and the character classifier of the window scanner.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int CUTOFF_W    = 12;
  localparam int SCORE_W     = 20;
  localparam int IDX_W       = 32;
  localparam int SCORE_SHIFT = 8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  localparam logic STRAND_FWD = 1'b0;
  localparam logic STRAND_CMP = 1'b1;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_T = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_C = 2'd3;

  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_T       = 8'h54;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_UP_Z    = 8'h5a;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // code layout: [3] uppercase, [2] is a base, [1:0] base
  localparam int CODE_UPPER_BIT = 3;
  localparam int CODE_BASE_BIT  = 2;

  typedef logic [3:0] code_t;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        weight_position;
    logic [1:0]        weight_base;
    logic signed [15:0] weight_value;
    logic [7:0]        base_char;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic                      strand;
    logic [IDX_W-1:0]          window_start;
    logic [IDX_W-1:0]          window_end;
    logic signed [SCORE_W-1:0] window_score;
    logic                      last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] end_idx;
  } meta_t;

  function automatic code_t classify(input logic [7:0] ch);
    logic       upper;
    logic       lower;
    logic [7:0] u;
    code_t      c;
    upper = (ch >= CHAR_A) && (ch <= CHAR_UP_Z);
    lower = (ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z);
    u = lower ? (ch - CASE_OFFSET) : ch;
    c = {upper, 3'b000};
    case (u)
      CHAR_A:  c[2:0] = {1'b1, BASE_A};
      CHAR_T:  c[2:0] = {1'b1, BASE_T};
      CHAR_G:  c[2:0] = {1'b1, BASE_G};
      CHAR_C:  c[2:0] = {1'b1, BASE_C};
      default: c[2:0] = 3'b000;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/pssm_window_scanner.sv
// ----------------------------------------------------------------------------
// pssm_window_scanner
// Sliding-window weight matrix scanner: a chain of window cells, a
// registered adder tree per strand pair and a two-word output register.
// ----------------------------------------------------------------------------
// path: a character is registered into the cell codes, then the terms, each adder level and the output register
// throughput: one word per cycle while out_ready is high; a character whose window passes on both
//   strands sends both words, forward first, through the single output port
// every stage is gated by its own valid bit, so bubbles collapse under stall
// reset: synchronous, clears the window, position, fill and cutoff; weights
//   hold whatever was last loaded
module pssm_window_scanner #(
  parameter int WINDOW_LEN     = 16,
  parameter int WEIGHT_WIDTH   = 16,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pwsc_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pwsc_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [pwsc_pkg::CUTOFF_W-1:0] cfg_data
);
  import pwsc_pkg::*;

  localparam int SUM_W  = WEIGHT_WIDTH + $clog2(WINDOW_LEN) + 1;
  localparam int ACC_W  = (SUM_W > SCORE_W + 1) ? SUM_W : SCORE_W + 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int PW     = POSITION_WIDTH;
  localparam logic signed [32:0] W_HI = 33'((64'sd1 <<< (WEIGHT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

  logic signed [CUTOFF_W-1:0]     cutoff_r;
  logic [PW-1:0]                  pos_r;
  logic [PW-1:0]                  pos_nxt;
  logic [FILL_W-1:0]              fill_r;
  logic [FILL_W-1:0]              fill_nxt;
  logic [FILL_W-1:0]              age_r;
  logic [FILL_W-1:0]              age_nxt;
  logic                           pend_r;
  meta_t                          pend_meta_r;
  meta_t                          meta_nxt;

  logic                           accept;
  logic                           char_acc;
  logic                           load_acc;
  logic                           s0_en;
  logic                           leaf_en;
  logic [PW-1:0]                  idx;
  logic [FILL_W-1:0]              fill_base;
  logic [FILL_W-1:0]              age_base;
  logic [PW-1:0]                  start_full;
  logic [PW-1:0]                  end_full;
  logic [PW+IDX_W-1:0]            start_ext;
  logic [PW+IDX_W-1:0]            end_ext;
  code_t                          new_code;
  logic signed [32:0]             wv_ext;
  logic signed [32:0]             wv_sat;
  logic signed [WEIGHT_WIDTH-1:0] wr_value;

  code_t                          cell_code [WINDOW_LEN];
  logic signed [WEIGHT_WIDTH-1:0] term_f [WINDOW_LEN];
  logic signed [WEIGHT_WIDTH-1:0] term_c [WINDOW_LEN];

  logic                           root_valid;
  logic signed [ACC_W-1:0]        root_f;
  logic signed [ACC_W-1:0]        root_c;
  meta_t                          root_meta;
  logic                           root_en;

  assign cfg_ready = 1'b1;
  assign s0_en     = !pend_r || leaf_en;
  assign in_ready  = s0_en;
  assign accept    = in_valid && in_ready;
  assign char_acc  = accept && (in_data.req_type == REQ_CHAR);
  assign load_acc  = accept && (in_data.req_type == REQ_LOAD);
  assign new_code  = classify(in_data.base_char);

  always_comb begin
    wv_ext = 33'(in_data.weight_value);
    if (wv_ext > W_HI) begin
      wv_sat = W_HI;
    end else if (wv_ext < W_LO) begin
      wv_sat = W_LO;
    end else begin
      wv_sat = wv_ext;
    end
    wr_value = wv_sat[WEIGHT_WIDTH-1:0];
  end

  // position, fill and distance back to the latest base
  always_comb begin
    idx       = in_data.restart ? '0 : pos_r;
    fill_base = in_data.restart ? '0 : fill_r;
    age_base  = in_data.restart ? FILL_W'(WINDOW_LEN) : age_r;
    pos_nxt   = (idx != '1) ? idx + PW'(1) : idx;
    fill_nxt  = (fill_base < FILL_W'(WINDOW_LEN)) ? fill_base + FILL_W'(1) : fill_base;
    if (new_code[CODE_BASE_BIT]) begin
      age_nxt = '0;
    end else if (age_base < FILL_W'(WINDOW_LEN)) begin
      age_nxt = age_base + FILL_W'(1);
    end else begin
      age_nxt = age_base;
    end
    start_full = idx - PW'(WINDOW_LEN - 1);
    end_full   = (age_nxt < FILL_W'(WINDOW_LEN)) ? idx - PW'(age_nxt) : '0;
    start_ext  = {{IDX_W{1'b0}}, start_full};
    end_ext    = {{IDX_W{1'b0}}, end_full};
    meta_nxt.start_idx = start_ext[IDX_W-1:0];
    meta_nxt.end_idx   = end_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cutoff_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      age_r  <= FILL_W'(WINDOW_LEN);
    end else if (char_acc) begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      age_r  <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (s0_en) begin
      pend_r <= char_acc && (fill_nxt == FILL_W'(WINDOW_LEN));
    end
  end

  always_ff @(posedge clk) begin
    if (char_acc) begin
      pend_meta_r <= meta_nxt;
    end
  end

  for (genvar j = 0; j < WINDOW_LEN; j++) begin : g_cell
    code_t code_in;
    if (j == WINDOW_LEN - 1) begin : g_tail
      assign code_in = new_code;
    end else begin : g_body
      assign code_in = in_data.restart ? '0 : cell_code[j+1];
    end

    pwsc_cell #(
      .WEIGHT_WIDTH(WEIGHT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (char_acc),
      .code_in  (code_in),
      .code_out (cell_code[j]),
      .wr_en    (load_acc && (32'(in_data.weight_position) == 32'(j))),
      .wr_base  (in_data.weight_base),
      .wr_value (wr_value),
      .term_en  (leaf_en),
      .term_f_r (term_f[j]),
      .term_c_r (term_c[j])
    );
  end

  pwsc_sum_tree #(
    .N            (WINDOW_LEN),
    .WEIGHT_WIDTH (WEIGHT_WIDTH),
    .ACC_W        (ACC_W)
  ) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .leaf_valid (pend_r),
    .leaf_meta  (pend_meta_r),
    .leaf_en    (leaf_en),
    .leaf_f     (term_f),
    .leaf_c     (term_c),
    .root_valid (root_valid),
    .root_f     (root_f),
    .root_c     (root_c),
    .root_meta  (root_meta),
    .root_en    (root_en)
  );

  pwsc_emitter #(
    .ACC_W (ACC_W)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cutoff     (cutoff_r),
    .root_valid (root_valid),
    .root_f     (root_f),
    .root_c     (root_c),
    .root_meta  (root_meta),
    .load_en    (root_en),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: hdl/pwsc_cell.sv
// ----------------------------------------------------------------------------
// pwsc_cell
// One window position: its character code, its four weights and the
// registered forward and complement terms.
// ----------------------------------------------------------------------------
module pwsc_cell #(
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  pwsc_pkg::code_t                code_in,
  output pwsc_pkg::code_t                code_out,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_base,
  input  logic signed [WEIGHT_WIDTH-1:0] wr_value,
  input  logic                           term_en,
  output logic signed [WEIGHT_WIDTH-1:0] term_f_r,
  output logic signed [WEIGHT_WIDTH-1:0] term_c_r
);
  import pwsc_pkg::*;

  code_t                         code_r;
  logic signed [WEIGHT_WIDTH-1:0] weight_r [4];
  logic [1:0]                    base_f;
  logic [1:0]                    base_c;
  logic                          is_base;

  assign code_out = code_r;
  assign is_base  = code_r[CODE_BASE_BIT];
  assign base_f   = code_r[1:0];
  // uppercase bases swap A/T and G/C on the complement strand
  assign base_c   = code_r[1:0] ^ {1'b0, code_r[CODE_UPPER_BIT]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else if (shift_en) begin
      code_r <= code_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_r[wr_base] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (term_en) begin
      term_f_r <= is_base ? weight_r[base_f] : '0;
      term_c_r <= is_base ? weight_r[base_c] : '0;
    end
  end

endmodule

FILE: hdl/pwsc_sum_tree.sv
// ----------------------------------------------------------------------------
// pwsc_sum_tree
// Registered binary adder tree over the cell terms, both strands side by
// side, with the window indices carried along each level.
// ----------------------------------------------------------------------------
module pwsc_sum_tree #(
  parameter int N            = 16,
  parameter int WEIGHT_WIDTH = 16,
  parameter int ACC_W        = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           leaf_valid,
  input  pwsc_pkg::meta_t                leaf_meta,
  output logic                           leaf_en,
  input  logic signed [WEIGHT_WIDTH-1:0] leaf_f [N],
  input  logic signed [WEIGHT_WIDTH-1:0] leaf_c [N],
  output logic                           root_valid,
  output logic signed [ACC_W-1:0]        root_f,
  output logic signed [ACC_W-1:0]        root_c,
  output pwsc_pkg::meta_t                root_meta,
  input  logic                           root_en
);
  import pwsc_pkg::*;

  localparam int L = $clog2(N);
  localparam int P = 1 << L;

  logic [L:0]              v_r;
  logic [L:0]              en;
  meta_t                   meta_r [L+1];
  logic signed [ACC_W-1:0] node_f_r [1:P-1];
  logic signed [ACC_W-1:0] node_c_r [1:P-1];

  always_comb begin
    en[0] = !v_r[0] || root_en;
    for (int d = 1; d <= L; d++) begin
      en[d] = !v_r[d] || en[d-1];
    end
  end

  assign leaf_en    = en[L];
  assign root_valid = v_r[0];
  assign root_f     = node_f_r[1];
  assign root_c     = node_c_r[1];
  assign root_meta  = meta_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int d = 0; d < L; d++) begin
        if (en[d]) begin
          v_r[d] <= v_r[d+1];
        end
      end
      if (en[L]) begin
        v_r[L] <= leaf_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < L; d++) begin
      if (en[d]) begin
        meta_r[d] <= meta_r[d+1];
      end
    end
    if (en[L]) begin
      meta_r[L] <= leaf_meta;
    end
  end

  for (genvar i = 1; i < P; i++) begin : g_node
    localparam int D = $clog2(i + 1) - 1;
    logic signed [ACC_W-1:0] lf;
    logic signed [ACC_W-1:0] rf;
    logic signed [ACC_W-1:0] lc;
    logic signed [ACC_W-1:0] rc;

    if (2 * i >= P) begin : g_leaf
      if (2 * i - P < N) begin : g_left
        assign lf = ACC_W'(leaf_f[2*i-P]);
        assign lc = ACC_W'(leaf_c[2*i-P]);
      end else begin : g_left_pad
        assign lf = '0;
        assign lc = '0;
      end
      if (2 * i + 1 - P < N) begin : g_right
        assign rf = ACC_W'(leaf_f[2*i+1-P]);
        assign rc = ACC_W'(leaf_c[2*i+1-P]);
      end else begin : g_right_pad
        assign rf = '0;
        assign rc = '0;
      end
    end else begin : g_inner
      assign lf = node_f_r[2*i];
      assign rf = node_f_r[2*i+1];
      assign lc = node_c_r[2*i];
      assign rc = node_c_r[2*i+1];
    end

    always_ff @(posedge clk) begin
      if (en[D]) begin
        node_f_r[i] <= lf + rf;
        node_c_r[i] <= lc + rc;
      end
    end
  end

endmodule

FILE: hdl/pwsc_emitter.sv
// ----------------------------------------------------------------------------
// pwsc_emitter
// Threshold test and score saturation, and the output register that hands
// out the forward word and then the complement word.
// ----------------------------------------------------------------------------
module pwsc_emitter #(
  parameter int ACC_W = 21
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [pwsc_pkg::CUTOFF_W-1:0]  cutoff,
  input  logic                                  root_valid,
  input  logic signed [ACC_W-1:0]               root_f,
  input  logic signed [ACC_W-1:0]               root_c,
  input  pwsc_pkg::meta_t                       root_meta,
  output logic                                  load_en,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pwsc_pkg::out_word_t                   out_data
);
  import pwsc_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic                      fwd_pend_r;
  logic                      cmp_pend_r;
  logic signed [SCORE_W-1:0] fwd_score_r;
  logic signed [SCORE_W-1:0] cmp_score_r;
  meta_t                     meta_r;
  logic signed [ACC_W-1:0]   thr;
  logic                      take;
  logic                      last_word;

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    t = s;
    if (s > SAT_HI) begin
      t = SAT_HI;
    end else if (s < SAT_LO) begin
      t = SAT_LO;
    end
    return t[SCORE_W-1:0];
  endfunction

  assign thr       = ACC_W'(cutoff) <<< SCORE_SHIFT;
  assign out_valid = fwd_pend_r || cmp_pend_r;
  assign last_word = !(fwd_pend_r && cmp_pend_r);
  assign take      = out_valid && out_ready;
  assign load_en   = !out_valid || (take && last_word);

  always_comb begin
    out_data.strand       = fwd_pend_r ? STRAND_FWD : STRAND_CMP;
    out_data.window_start = meta_r.start_idx;
    out_data.window_end   = meta_r.end_idx;
    out_data.window_score = fwd_pend_r ? fwd_score_r : cmp_score_r;
    out_data.last_of_run  = last_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_pend_r <= 1'b0;
      cmp_pend_r <= 1'b0;
    end else if (load_en) begin
      fwd_pend_r <= root_valid && (root_f > thr);
      cmp_pend_r <= root_valid && (root_c > thr);
    end else if (take) begin
      fwd_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      fwd_score_r <= sat_score(root_f);
      cmp_score_r <= sat_score(root_c);
      meta_r      <= root_meta;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window weight matrix scanner. It fills
// the weight table, runs directed windows at the score and cutoff extremes,
// then long random DNA streams under several cutoffs. Both channels idle at
// random, and every output word is compared with a scoring model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import pwsc_pkg::*;

  localparam int WIN        = 16;
  localparam int TAB        = WIN * 4;
  localparam int LATENCY    = 7;
  localparam int SETTLE     = LATENCY + 9;
  localparam int GAP_MAX    = 14;
  localparam int RAND_ITEMS = 1950;
  localparam int PHASES     = 6;
  localparam int SCORE_MAX  = (1 << (SCORE_W - 1)) - 1;
  localparam int SCORE_MIN  = -(1 << (SCORE_W - 1));
  localparam int CUTOFF_MAX = (1 << (CUTOFF_W - 1)) - 1;
  localparam int CUTOFF_MIN = -(1 << (CUTOFF_W - 1));
  localparam logic [7:0] LETTERS [4] = '{CHAR_A, CHAR_T, CHAR_G, CHAR_C};

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  in_word_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  out_word_t                  out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic signed [CUTOFF_W-1:0] cfg_data;

  pssm_window_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // scoring model state
  logic signed [15:0] weight_mem [TAB];
  code_t              win_code [WIN];
  logic [IDX_W-1:0]   next_index;
  int                 win_fill;
  int                 cutoff_val;
  out_word_t          hit_queue [$];

  int errors;
  int chars_sent;
  int loads_sent;
  int words_checked;
  int cutoffs_used;
  bit send_idle;
  bit recv_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic code_t char_code(input logic [7:0] ch);
    logic [7:0] up;
    code_t      c;
    c = '0;
    c[CODE_UPPER_BIT] = (ch >= CHAR_A) && (ch <= CHAR_UP_Z);
    up = ((ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z)) ? ch - CASE_OFFSET : ch;
    for (int i = 0; i < 4; i++) begin
      if (up == LETTERS[i]) begin
        c[CODE_BASE_BIT] = 1'b1;
        c[1:0] = i[1:0];
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic void add_hit(input logic strand, input logic [IDX_W-1:0] first,
                                  input logic [IDX_W-1:0] last, input int sum,
                                  input logic is_last);
    out_word_t r;
    if (sum > SCORE_MAX) sum = SCORE_MAX;
    if (sum < SCORE_MIN) sum = SCORE_MIN;
    r.strand       = strand;
    r.window_start = first;
    r.window_end   = last;
    r.window_score = sum[SCORE_W-1:0];
    r.last_of_run  = is_last;
    hit_queue.insert(hit_queue.size(), r);
  endfunction

  function automatic void score_char(input in_word_t w);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [1:0]       b;
    int               fwd;
    int               cmp;
    int               thr;
    int               j;
    bit               fwd_hit;
    bit               cmp_hit;
    if (w.restart) begin
      next_index = '0;
      win_fill = 0;
      for (j = 0; j < WIN; j++) win_code[j] = '0;
    end
    idx = next_index;
    if (next_index != '1) next_index++;
    for (j = 0; j < WIN - 1; j++) win_code[j] = win_code[j + 1];
    win_code[WIN - 1] = char_code(w.base_char);
    if (win_fill < WIN) win_fill++;
    if (win_fill < WIN) return;
    first = idx - (WIN - 1);
    last = '0;
    fwd = 0;
    cmp = 0;
    for (j = 0; j < WIN; j++) begin
      if (win_code[j][CODE_BASE_BIT]) begin
        last = first + j;
        b = win_code[j][1:0];
        fwd += weight_mem[j * 4 + b];
        // uppercase pairs A-T and G-C swap on the complement strand
        if (win_code[j][CODE_UPPER_BIT]) b = b ^ 2'b01;
        cmp += weight_mem[j * 4 + b];
      end
    end
    thr = cutoff_val * 256;
    fwd_hit = fwd > thr;
    cmp_hit = cmp > thr;
    if (fwd_hit) add_hit(STRAND_FWD, first, last, fwd, !cmp_hit);
    if (cmp_hit) add_hit(STRAND_CMP, first, last, cmp, 1'b1);
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (hit_queue.size() == 0) begin
      report_mismatch("word with nothing expected, start", got.window_start, '0);
      return;
    end
    want = hit_queue.pop_front();
    words_checked++;
    if (got.strand !== want.strand)
      report_mismatch("strand", got.strand, want.strand);
    if (got.window_start !== want.window_start)
      report_mismatch("window_start", got.window_start, want.window_start);
    if (got.window_end !== want.window_end)
      report_mismatch("window_end", got.window_end, want.window_end);
    if (got.window_score !== want.window_score)
      report_mismatch("window_score", got.window_score, want.window_score);
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_word(out_data);
      if (cfg_valid && cfg_ready) cutoff_val = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_CHAR)
          score_char(in_data);
        else
          weight_mem[in_data.weight_position * 4 + in_data.weight_base] =
            in_data.weight_value;
      end
    end
  end

  // result side: random stall before each word while recv_idle is set
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_word_t load_word(input int pos, input int base, input int value);
    in_word_t w;
    w = $urandom;
    w.req_type = REQ_LOAD;
    w.weight_position = pos[3:0];
    w.weight_base = base[1:0];
    w.weight_value = value[15:0];
    return w;
  endfunction

  function automatic in_word_t char_word(input logic [7:0] ch, input logic rs);
    in_word_t w;
    w = $urandom;
    w.req_type = REQ_CHAR;
    w.base_char = ch;
    w.restart = rs;
    return w;
  endfunction

  function automatic logic [7:0] non_base_char();
    logic [7:0] ch;
    code_t      c;
    do begin
      ch = 8'($urandom_range(0, 255));
      c = char_code(ch);
    end while (c[CODE_BASE_BIT]);
    return ch;
  endfunction

  function automatic logic [7:0] stream_char();
    logic [7:0] ch;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    ch = LETTERS[$urandom_range(0, 3)];
    if ($urandom_range(0, 1)) ch = ch + CASE_OFFSET;
    return ch;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.req_type == REQ_CHAR) chars_sent++;
    else loads_sent++;
  endtask

  // stop input, wait for all expected words, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cutoff(input int value);
    cfg_valid <= 1'b1;
    cfg_data <= value[CUTOFF_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cutoffs_used++;
  endtask

  task automatic test_weight_table();
    for (int p = 0; p < WIN; p++)
      for (int b = 0; b < 4; b++)
        send_word(load_word(p, b, $urandom_range(0, 65535) - 32768));
  endtask

  // A weights at the top, T at the bottom: full-scale scores on both strands
  task automatic test_extreme_windows();
    logic [7:0] probe [8];
    probe = '{CHAR_A + CASE_OFFSET, CHAR_T, CHAR_T + CASE_OFFSET, CHAR_G,
              CHAR_C + CASE_OFFSET, 8'h4e, 8'h00, 8'hff};
    drain();
    set_cutoff(CUTOFF_MIN);
    for (int p = 0; p < WIN; p++) begin
      send_word(load_word(p, BASE_A, 32767));
      send_word(load_word(p, BASE_T, -32768));
    end
    for (int i = 0; i < WIN; i++) send_word(char_word(CHAR_A, i == 0));
    for (int i = 0; i < 8; i++) send_word(char_word(probe[i], 1'b0));
  endtask

  task automatic test_empty_window();
    for (int i = 0; i < WIN; i++) send_word(char_word(non_base_char(), i == 0));
  endtask

  task automatic test_random_stream(input int phase, input int count);
    int cut;
    int r;
    int v;
    case (phase)
      0:       cut = CUTOFF_MAX;
      1:       cut = CUTOFF_MIN;
      default: cut = $urandom_range(0, 800) - 400;
    endcase
    drain();
    set_cutoff(cut);
    send_idle = phase[0];
    recv_idle = phase[1] | (phase == 4);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 9))
          0:       v = 32767;
          1:       v = -32768;
          default: v = $urandom_range(0, 65535) - 32768;
        endcase
        send_word(load_word($urandom_range(0, WIN - 1), $urandom_range(0, 3), v));
      end else begin
        send_word(char_word(stream_char(), r < 8));
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    errors = 0;
    chars_sent = 0;
    loads_sent = 0;
    words_checked = 0;
    cutoffs_used = 0;
    next_index = '0;
    win_fill = 0;
    cutoff_val = 0;
    for (int j = 0; j < WIN; j++) win_code[j] = '0;
    for (int j = 0; j < TAB; j++) weight_mem[j] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_weight_table();
    test_extreme_windows();
    test_empty_window();
    for (int ph = 0; ph < PHASES; ph++) test_random_stream(ph, RAND_ITEMS / PHASES);
    drain();
    $display("sent %0d characters and %0d weight loads, checked %0d result words",
             chars_sent, loads_sent, words_checked);
    $display("ran under %0d cutoff settings, %0d mismatches", cutoffs_used, errors);
    if (errors == 0)
      $display("pssm_window_scanner verification clean");
    else
      $display("pssm_window_scanner verification failed");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("pssm_window_scanner verification failed");
    $finish;
  end

endmodule
